// ===== rtl/core/rank_addressed_sequence_store_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file rass_checker
// Each macro places one labeled concurrent assertion, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef RANK_ADDRESSED_SEQUENCE_STORE_MACROS_SVH
`define RANK_ADDRESSED_SEQUENCE_STORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds too.
`define RASS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define RASS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/rass_pkg.sv =====
// ----------------------------------------------------------------------------
// rass_pkg
// Shared types, codes and widths of the rank-addressed sequence store.
// ----------------------------------------------------------------------------
package rass_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 7;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 3;

    // request codes (6 and 7 are unused and behave as no-ops)
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_RANK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REPLACE   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FIND      = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [RANK_W-1:0]         rank;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RANK_W-1:0]   match_rank;
        logic [RANK_W-1:0]   entry_count;
        logic                last_result;
    } t_result;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_REPLACE
    } t_cell_op;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op          op;
        logic [RANK_W-1:0] pos;   // zero-based target index
    } t_cell_ctl;

    // one find hit from the scanner
    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] match_rank;
        logic              last;
    } t_scan_out;

endpackage

// ===== rtl/core/rass_cell.sv =====
// ----------------------------------------------------------------------------
// rass_cell
// One entry of the chain: holds a value, shifts with its neighbors, compares.
// ----------------------------------------------------------------------------
module rass_cell #(
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  rass_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [rass_pkg::VALUE_W-1:0] i_new,
    input  logic signed [rass_pkg::VALUE_W-1:0] i_left,   // entry IDX-1
    input  logic signed [rass_pkg::VALUE_W-1:0] i_right,  // entry IDX+1
    input  logic signed [rass_pkg::VALUE_W-1:0] i_key,
    output logic signed [rass_pkg::VALUE_W-1:0] o_value,
    output logic                                o_match
);

    localparam logic [rass_pkg::RANK_W-1:0] MY_IDX = rass_pkg::RANK_W'(IDX);

    logic signed [rass_pkg::VALUE_W-1:0] r_value;
    logic signed [rass_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            rass_pkg::CELL_INSERT: begin
                if (MY_IDX == i_ctl.pos) begin
                    n_value = i_new;
                end else if (MY_IDX > i_ctl.pos) begin
                    n_value = i_left;
                end
            end
            rass_pkg::CELL_DELETE: begin
                if (MY_IDX >= i_ctl.pos) begin
                    n_value = i_right;
                end
            end
            rass_pkg::CELL_REPLACE: begin
                if (MY_IDX == i_ctl.pos) begin
                    n_value = i_new;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_key);

endmodule

// ===== rtl/core/rass_scan.sv =====
// ----------------------------------------------------------------------------
// rass_scan
// Find-hit scanner: walks a registered hit mask lowest rank first, one a cycle.
// ----------------------------------------------------------------------------
module rass_scan #(
    parameter int DEPTH = rass_pkg::DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [DEPTH-1:0]      i_mask,
    output logic                  o_busy,
    output rass_pkg::t_scan_out   o_scan
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [DEPTH-1:0] r_mask;
    logic [DEPTH-1:0] n_mask;
    logic [IDX_W-1:0] w_idx;

    // lowest set bit
    always_comb begin
        w_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_mask = r_mask & (r_mask - DEPTH'(1));
        if (i_load) begin
            n_mask = i_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    assign o_busy            = (r_mask != '0);
    assign o_scan.valid      = (r_mask != '0);
    assign o_scan.match_rank = rass_pkg::RANK_W'(w_idx) + rass_pkg::RANK_W'(1);
    assign o_scan.last       = ((r_mask & (r_mask - DEPTH'(1))) == '0);

endmodule

// ===== rtl/core/rank_addressed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// rank_addressed_sequence_store
// Ordered store of signed 32-bit values addressed by one-based rank.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Insert, delete,
// replace, unused codes and any request that fails its checks finish at the
// edge that takes them, where the chain of cells shifts or writes; the single
// result appears on o_result with o_strobe high in the next cycle, while a new
// request may already be taken. A find whose value matches k stored entries
// holds busy high while its hits drain and emits k results on consecutive
// cycles, lowest rank first, through the scanner mask and result registers;
// the hit scanner retires one match per cycle. A find with no match, or on an
// empty store, gives one result like any other request. Results cannot be
// held off: each is valid for exactly the one cycle that o_strobe marks.
// Entries carry no reset; only entries below the count can ever hit.
// ----------------------------------------------------------------------------
module rank_addressed_sequence_store #(
    parameter int DEPTH = rass_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rass_pkg::t_req     i_req,
    output logic               o_strobe,
    output rass_pkg::t_result  o_result
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RW    = rass_pkg::RANK_W;

    // entry count
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic              r_strobe;
    logic              n_strobe;
    rass_pkg::t_result r_result;
    rass_pkg::t_result n_result;

    // chain wiring
    rass_pkg::t_cell_ctl                 w_ctl;
    logic signed [rass_pkg::VALUE_W-1:0] w_val [DEPTH];
    logic [DEPTH-1:0]                    w_hit;

    // scanner
    logic                w_scan_busy;
    logic                w_scan_load;
    rass_pkg::t_scan_out w_scan;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_rank_ok;   // rank within 1..count
    logic [RW-1:0]    w_count_ext;

    assign w_accept    = start && !busy;
    assign w_count_ext = RW'(r_count);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_rank_ok   = (i_req.rank != '0) && (i_req.rank <= w_count_ext);

    // ---- cell chain ----
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [rass_pkg::VALUE_W-1:0] w_left;
        logic signed [rass_pkg::VALUE_W-1:0] w_right;
        logic                                w_match;

        if (g == 0) begin : g_first
            assign w_left = i_req.value;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        rass_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_new   (i_req.value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_key   (i_req.value),
            .o_value (w_val[g]),
            .o_match (w_match)
        );

        // only live entries may hit
        assign w_hit[g] = w_match && (CNT_W'(g) < r_count);
    end

    // ---- request decode ----
    always_comb begin
        w_ctl.op    = rass_pkg::CELL_HOLD;
        w_ctl.pos   = '0;
        w_scan_load = 1'b0;
        n_count     = r_count;
        n_strobe    = 1'b0;
        n_result    = r_result;

        if (w_accept) begin
            n_strobe             = 1'b1;
            n_result.status      = rass_pkg::ST_OK;
            n_result.match_rank  = '0;
            n_result.last_result = 1'b1;
            priority if (i_req.req_type == rass_pkg::REQ_INS_FRONT ||
                         i_req.req_type == rass_pkg::REQ_INS_BACK) begin
                if (w_full) begin
                    n_result.status = rass_pkg::ST_FULL;
                end else begin
                    w_ctl.op  = rass_pkg::CELL_INSERT;
                    w_ctl.pos = (i_req.req_type == rass_pkg::REQ_INS_FRONT) ?
                                '0 : w_count_ext;
                    n_count   = r_count + CNT_W'(1);
                end
            end else if (i_req.req_type == rass_pkg::REQ_INS_RANK) begin
                if (w_full) begin
                    n_result.status = rass_pkg::ST_FULL;
                end else if (i_req.rank == RW'(1) || w_rank_ok) begin
                    w_ctl.op  = rass_pkg::CELL_INSERT;
                    w_ctl.pos = i_req.rank - RW'(1);
                    n_count   = r_count + CNT_W'(1);
                end else begin
                    n_result.status = rass_pkg::ST_RANGE;
                end
            end else if (i_req.req_type == rass_pkg::REQ_DELETE ||
                         i_req.req_type == rass_pkg::REQ_REPLACE) begin
                if (w_empty) begin
                    n_result.status = rass_pkg::ST_EMPTY;
                end else if (!w_rank_ok) begin
                    n_result.status = rass_pkg::ST_RANGE;
                end else if (i_req.req_type == rass_pkg::REQ_DELETE) begin
                    w_ctl.op  = rass_pkg::CELL_DELETE;
                    w_ctl.pos = i_req.rank - RW'(1);
                    n_count   = r_count - CNT_W'(1);
                end else begin
                    w_ctl.op  = rass_pkg::CELL_REPLACE;
                    w_ctl.pos = i_req.rank - RW'(1);
                end
            end else if (i_req.req_type == rass_pkg::REQ_FIND) begin
                if (w_empty) begin
                    n_result.status = rass_pkg::ST_EMPTY;
                end else if (w_hit == '0) begin
                    n_result.status = rass_pkg::ST_NOTFOUND;
                end else begin
                    // hits leave through the scanner
                    w_scan_load = 1'b1;
                    n_strobe    = 1'b0;
                end
            end else begin
                n_result.status = rass_pkg::ST_OK;   // unused code: no-op
            end
            n_result.entry_count = RW'(n_count);
        end else if (w_scan.valid) begin
            n_strobe             = 1'b1;
            n_result.status      = rass_pkg::ST_OK;
            n_result.match_rank  = w_scan.match_rank;
            n_result.entry_count = w_count_ext;
            n_result.last_result = w_scan.last;
        end
    end

    rass_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_scan_load),
        .i_mask  (w_hit),
        .o_busy  (w_scan_busy),
        .o_scan  (w_scan)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = w_scan_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/core/rass_checker.sv =====
// ----------------------------------------------------------------------------
// rass_checker
// Port-level checks of the sequence store, bound onto the top level.
// ----------------------------------------------------------------------------
`include "rank_addressed_sequence_store_macros.svh"

module rass_checker #(
    parameter int DEPTH = rass_pkg::DEPTH_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input rass_pkg::t_req     i_req,
    input logic               o_strobe,
    input rass_pkg::t_result  o_result
);

    localparam logic [rass_pkg::RANK_W-1:0] CAP = rass_pkg::RANK_W'(DEPTH);

    // non-find request taken this cycle
    logic w_take_plain;
    assign w_take_plain = start && !busy && (i_req.req_type != rass_pkg::REQ_FIND);

    // count never exceeds capacity
    `RASS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, o_strobe, o_result.entry_count <= CAP)

    // find hits come back to back until the last one
    `RASS_ASSERT_NEXT(a_hits_burst, i_clk, i_rst_n, o_strobe && !o_result.last_result, o_strobe)

    // a failed request is a lone result without a rank
    `RASS_ASSERT_NOW(a_err_single, i_clk, i_rst_n, o_strobe && o_result.status != rass_pkg::ST_OK, o_result.last_result && o_result.match_rank == '0)

    // more hits pending keeps new requests out
    `RASS_ASSERT_NOW(a_busy_burst, i_clk, i_rst_n, o_strobe && !o_result.last_result, busy)

    // any request other than a find answers in the next cycle
    `RASS_ASSERT_NEXT(a_plain_answer, i_clk, i_rst_n, w_take_plain, o_strobe)

endmodule

bind rank_addressed_sequence_store rass_checker #(
    .DEPTH (DEPTH)
) u_rass_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
